### rtl/core/cmo_pkg.sv
// Shared types and constants for the chaos map oscillator.
// No dependencies; used by the top level, the core and the shared unit.
package cmo_pkg;

  // datapath width of the shared unit (wide enough for divisor << 16)
  localparam int DW = 54;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_RATE    = 2'd0;
  localparam logic [1:0] CFG_UPDATE_RATE  = 2'd1;
  localparam logic [1:0] CFG_INITIAL_SEED = 2'd2;
  localparam logic [1:0] CFG_MAP_MODE     = 2'd3;

  localparam logic [15:0] BASE_RATE_RST    = 16'd60621;
  localparam logic [15:0] UPDATE_RATE_RST  = 16'd11025;
  localparam logic [16:0] INITIAL_SEED_RST = 17'd32768;

  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [16:0] HALF_Q16      = 17'd32768;
  localparam logic [16:0] RATE_MIN      = 17'd16384;
  localparam logic [16:0] RATE_MAX      = 17'd65372;
  localparam logic [15:0] RATE_LOGI_MIN = 16'd49152;
  localparam logic [16:0] DEN_SCALE     = 17'd17;
  // 750000 * 65536: numerator of the iteration period
  localparam logic [DW-1:0] PERIOD_NUM  = 54'd49152000000;

  localparam logic MODE_LOGISTIC = 1'b0;
  localparam logic MODE_NFOLD    = 1'b1;

  typedef enum logic {
    ALU_MUL,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [15:0] base_rate;
    logic [15:0] update_rate_hz;
    logic [16:0] initial_seed;
    logic        map_mode;
  } cfg_t;

endpackage

### rtl/core/chaos_map_oscillator.sv
// A beat whose update rate or speed gain is zero goes straight to the output; otherwise
// the 16-step period division and 16-step tick modulo may run, then the map if due.
// The shared multiply/subtract unit serves one beat at a time, so no new beat is taken
// while busy. A waiting result does not block the next beat.
// Reset (rst_n low, synchronous): registers to defaults, seed to 0.5, no output, idle.
module chaos_map_oscillator #(
  parameter int SAMPLE_RATE = 44100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_rate_mod_sample,
  input  logic        in_rate_mod_valid,
  input  logic signed [15:0] in_speed_mod_sample,
  input  logic        in_speed_mod_valid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_sample_out
);

  cmo_pkg::cfg_t cfg_r;
  logic          busy;
  logic [15:0]   sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_rate      <= cmo_pkg::BASE_RATE_RST;
      cfg_r.update_rate_hz <= cmo_pkg::UPDATE_RATE_RST;
      cfg_r.initial_seed   <= cmo_pkg::INITIAL_SEED_RST;
      cfg_r.map_mode       <= cmo_pkg::MODE_LOGISTIC;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cmo_pkg::CFG_BASE_RATE:    cfg_r.base_rate      <= cfg_wdata[15:0];
        cmo_pkg::CFG_UPDATE_RATE:  cfg_r.update_rate_hz <= cfg_wdata[15:0];
        cmo_pkg::CFG_INITIAL_SEED: cfg_r.initial_seed   <= cfg_wdata;
        cmo_pkg::CFG_MAP_MODE:     cfg_r.map_mode       <= cfg_wdata[0];
      endcase
    end
  end

  cmo_core #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .start            (in_valid & ~busy),
    .rate_mod_sample  (in_rate_mod_sample),
    .rate_mod_valid   (in_rate_mod_valid),
    .speed_mod_sample (in_speed_mod_sample),
    .speed_mod_valid  (in_speed_mod_valid),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (sample)
  );

  assign in_stall       = busy;
  assign out_sample_out = sample;

endmodule

### rtl/core/cmo_alu.sv
// Shared arithmetic unit: 33x17 multiply or wide subtract with borrow.
// Depends on cmo_pkg.
module cmo_alu (
  input  cmo_pkg::alu_op_t          op,
  input  logic [cmo_pkg::DW-1:0]    a,
  input  logic [cmo_pkg::DW-1:0]    b,
  output logic [cmo_pkg::DW-1:0]    res,
  output logic                      borrow
);

  logic [49:0]             prod;
  logic [cmo_pkg::DW:0]    diff;

  assign prod = a[32:0] * b[16:0];
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    unique case (op)
      cmo_pkg::ALU_MUL: begin
        res    = {{(cmo_pkg::DW-50){1'b0}}, prod};
        borrow = 1'b0;
      end
      cmo_pkg::ALU_SUB: begin
        res    = diff[cmo_pkg::DW-1:0];
        borrow = diff[cmo_pkg::DW];
      end
    endcase
  end

endmodule

### rtl/core/cmo_core.sv
// Sequencer and datapath: period division, tick modulo and map iteration,
// all on the shared unit. Depends on cmo_pkg and cmo_alu.
module cmo_core #(
  parameter int SAMPLE_RATE = 44100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmo_pkg::cfg_t      cfg,
  input  logic               start,
  input  logic [15:0]        rate_mod_sample,
  input  logic               rate_mod_valid,
  input  logic [15:0]        speed_mod_sample,
  input  logic               speed_mod_valid,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_sample
);

  localparam int DW = cmo_pkg::DW;

  typedef enum logic [3:0] {
    S_IDLE, S_DEN1, S_DEN2, S_CHK0, S_CHK1, S_DIV, S_MOD,
    S_RATE, S_MAP1, S_MAP2, S_FIN, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [16:0]      rate_gain_r, rate_gain_nxt;
  logic [16:0]      speed_gain_r, speed_gain_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [16:0]      seed_r, seed_nxt;
  logic [15:0]      held_r, held_nxt;
  logic [DW-1:0]    acc_r, acc_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dv_r, dv_nxt;
  logic [15:0]      quo_r, quo_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [15:0]      rate_r, rate_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_sample_r, out_sample_nxt;

  cmo_pkg::alu_op_t alu_op;
  logic [DW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_borrow;

  logic [15:0]      logi_rate;
  logic [16:0]      rate_raw;
  logic [16:0]      seed_ld;
  logic [DW-1:0]    rem_step;
  logic [15:0]      quo_step;
  logic [16:0]      tick_inc;
  logic             out_free;

  cmo_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign logi_rate = (rate_r < cmo_pkg::RATE_LOGI_MIN) ? cmo_pkg::RATE_LOGI_MIN : rate_r;
  assign rate_raw  = alu_res[32:16];
  assign rem_step  = alu_borrow ? rem_r : alu_res;
  assign quo_step  = {quo_r[14:0], ~alu_borrow};
  assign tick_inc  = {1'b0, tick_r} + 17'd1;
  assign out_free  = ~out_valid_r | ~out_stall;

  // zero seed reloads, then clamp to 1.0
  always_comb begin
    seed_ld = (seed_r == 17'd0) ? cfg.initial_seed : seed_r;
    if (seed_ld > cmo_pkg::ONE_Q16) seed_ld = cmo_pkg::ONE_Q16;
  end

  // shared unit operand select
  always_comb begin
    alu_op = cmo_pkg::ALU_MUL;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_DEN1: begin
        alu_a = DW'(cfg.update_rate_hz);
        alu_b = DW'(cmo_pkg::DEN_SCALE);
      end
      S_DEN2: begin
        alu_a = DW'(acc_r[20:0]);
        alu_b = DW'(speed_gain_r);
      end
      S_CHK0: begin
        alu_op = cmo_pkg::ALU_SUB;
        alu_a  = cmo_pkg::PERIOD_NUM;
        alu_b  = acc_r;
      end
      S_CHK1: begin
        alu_op = cmo_pkg::ALU_SUB;
        alu_a  = cmo_pkg::PERIOD_NUM;
        alu_b  = acc_r << 16;
      end
      S_DIV, S_MOD: begin
        alu_op = cmo_pkg::ALU_SUB;
        alu_a  = rem_r;
        alu_b  = dv_r;
      end
      S_RATE: begin
        alu_a = DW'(cfg.base_rate);
        alu_b = DW'(rate_gain_r);
      end
      S_MAP1: begin
        alu_a = (cfg.map_mode == cmo_pkg::MODE_LOGISTIC) ? DW'(logi_rate) : DW'(rate_r);
        alu_b = DW'(seed_r);
      end
      S_MAP2: begin
        alu_a = DW'(acc_r[32:0]);
        alu_b = DW'(cmo_pkg::ONE_Q16 - seed_r);
      end
      S_IDLE, S_FIN, S_OUT: begin
        alu_a = '0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    rate_gain_nxt  = rate_gain_r;
    speed_gain_nxt = speed_gain_r;
    tick_nxt       = tick_r;
    seed_nxt       = seed_r;
    held_nxt       = held_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    dv_nxt         = dv_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    rate_nxt       = rate_r;
    out_sample_nxt = out_sample_r;
    out_valid_nxt  = out_valid_r & out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (rate_mod_valid)
            rate_gain_nxt = {1'b0, rate_mod_sample ^ 16'h8000} + cmo_pkg::HALF_Q16;
          if (speed_mod_valid)
            speed_gain_nxt = {1'b0, speed_mod_sample ^ 16'h8000};
          state_nxt = S_DEN1;
        end
      end
      S_DEN1: begin
        acc_nxt   = alu_res;
        state_nxt = S_DEN2;
      end
      S_DEN2: begin
        acc_nxt   = alu_res;
        state_nxt = S_CHK0;
      end
      S_CHK0: begin
        // zero denominator holds; period below one iterates every tick
        if (acc_r == '0)    state_nxt = S_OUT;
        else if (alu_borrow) state_nxt = S_RATE;
        else                 state_nxt = S_CHK1;
      end
      S_CHK1: begin
        if (!alu_borrow) begin
          // period exceeds any tick value
          state_nxt = (tick_r == 16'd0) ? S_RATE : S_OUT;
        end else begin
          rem_nxt   = cmo_pkg::PERIOD_NUM;
          dv_nxt    = acc_r << 15;
          quo_nxt   = '0;
          cnt_nxt   = 4'd15;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        dv_nxt  = dv_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          rem_nxt   = DW'(tick_r);
          dv_nxt    = DW'(quo_step) << 15;
          cnt_nxt   = 4'd15;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        rem_nxt = rem_step;
        dv_nxt  = dv_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0)
          state_nxt = (rem_step == '0) ? S_RATE : S_OUT;
      end
      S_RATE: begin
        if (rate_raw < cmo_pkg::RATE_MIN)      rate_nxt = cmo_pkg::RATE_MIN[15:0];
        else if (rate_raw > cmo_pkg::RATE_MAX) rate_nxt = cmo_pkg::RATE_MAX[15:0];
        else                                   rate_nxt = rate_raw[15:0];
        seed_nxt  = seed_ld;
        state_nxt = S_MAP1;
      end
      S_MAP1: begin
        if (cfg.map_mode == cmo_pkg::MODE_LOGISTIC) begin
          acc_nxt   = alu_res;
          state_nxt = S_MAP2;
        end else begin
          seed_nxt  = {1'b0, alu_res[29:14]};
          state_nxt = S_FIN;
        end
      end
      S_MAP2: begin
        seed_nxt  = alu_res[46:30];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // seed - 0.5, saturating at full scale
        held_nxt  = seed_r[16] ? 16'h7FFF : {~seed_r[15], seed_r[14:0]};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = held_r;
          tick_nxt       = (tick_inc >= 17'(SAMPLE_RATE)) ? 16'd0 : tick_inc[15:0];
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rate_gain_r  <= cmo_pkg::ONE_Q16;
      speed_gain_r <= cmo_pkg::ONE_Q16;
      tick_r       <= '0;
      seed_r       <= cmo_pkg::INITIAL_SEED_RST;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rate_gain_r  <= rate_gain_nxt;
      speed_gain_r <= speed_gain_nxt;
      tick_r       <= tick_nxt;
      seed_r       <= seed_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    rem_r        <= rem_nxt;
    dv_r         <= dv_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    rate_r       <= rate_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

### rtl/core/chaos_map_oscillator_chk.sv
// Port-level checker for chaos_map_oscillator, bound to the top level.
// Depends only on the top-level ports.
module chaos_map_oscillator_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_sample_out
);

  // an accepted beat keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepted beat");

  // a new result only appears while the block is still busy with its beat
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // no result while idle and nothing pending since the previous cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !in_stall) |=> !out_valid)
    else $error("result appeared from idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_out)))
    else $error("stalled result changed");

endmodule

bind chaos_map_oscillator chaos_map_oscillator_chk u_chk (.*);

### verif/tb_chaos_map_oscillator.sv
// Self-checking testbench for chaos_map_oscillator: directed ticks and random ticks
// across several register settings, checked by a local predictor.
// Depends on cmo_pkg (register indexes, map modes) and the chaos_map_oscillator RTL.
module tb_chaos_map_oscillator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_RATE     = 44100;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 64;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int PRESSURE_AT     = 450;

  // predictor constants, Q1.16 seed/gains and Q2.14 rate
  localparam logic [63:0] UNITY_Q16   = 64'd65536;
  localparam logic [63:0] RATE_FLOOR  = 64'd16384;
  localparam logic [63:0] RATE_CEIL   = 64'd65372;
  localparam logic [63:0] LOGI_FLOOR  = 64'd49152;
  localparam logic [63:0] PERIOD_NUMR = 64'd49152000000;
  localparam logic [63:0] PERIOD_DEN  = 64'd17;

  // indexes into the register setting table
  localparam int SET_KEEP     = -1;
  localparam int SET_ALL_LOW  = 0;
  localparam int SET_ALL_HIGH = 1;
  localparam int SET_DOUBLING = 2;
  localparam int SET_DEFAULT  = 3;
  localparam int SET_UNITY    = 4;
  localparam int SET_SLOW     = 5;
  localparam int SET_HOLD     = 6;
  localparam int SET_WRAP     = 7;
  localparam int SET_RANDOM   = 8;

  typedef struct packed {
    logic [15:0] base_rate;
    logic [15:0] update_rate;
    logic [16:0] seed;
    logic        mode;
  } osc_setting_t;

  typedef struct packed {
    logic signed [7:0]  setting;
    logic signed [15:0] rate_smp;
    logic               rate_vld;
    logic signed [15:0] speed_smp;
    logic               speed_vld;
    logic               known;
    logic signed [15:0] known_out;
  } tick_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_addr;
  logic [16:0]       cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic signed [15:0] in_rate_mod_sample;
  logic              in_rate_mod_valid;
  logic signed [15:0] in_speed_mod_sample;
  logic              in_speed_mod_valid;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [15:0] out_sample_out;

  chaos_map_oscillator #(.SAMPLE_RATE(SAMPLE_RATE)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rate_mod_sample  (in_rate_mod_sample),
    .in_rate_mod_valid   (in_rate_mod_valid),
    .in_speed_mod_sample (in_speed_mod_sample),
    .in_speed_mod_valid  (in_speed_mod_valid),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sample_out      (out_sample_out)
  );

  osc_setting_t setting_table [9] = '{
    '{16'd0,     16'd0,     17'd0,      cmo_pkg::MODE_NFOLD},
    '{16'd65535, 16'd65535, 17'd131071, cmo_pkg::MODE_LOGISTIC},
    '{16'd32768, 16'd44100, 17'd65536,  cmo_pkg::MODE_NFOLD},
    '{16'd60621, 16'd11025, 17'd32768,  cmo_pkg::MODE_LOGISTIC},
    '{16'd16384, 16'd300,   17'd1,      cmo_pkg::MODE_NFOLD},
    '{16'd57000, 16'd2000,  17'd40000,  cmo_pkg::MODE_LOGISTIC},
    '{16'd50000, 16'd0,     17'd20000,  cmo_pkg::MODE_LOGISTIC},
    // period 13 at unity speed gain: 13 does not divide the sample rate
    '{16'd62000, 16'd3300,  17'd30000,  cmo_pkg::MODE_LOGISTIC},
    '{16'd0,     16'd0,     17'd0,      cmo_pkg::MODE_LOGISTIC}
  };

  int phase_plan [PHASES] = '{SET_DEFAULT, SET_DOUBLING, SET_SLOW, SET_RANDOM,
                              SET_ALL_HIGH, SET_UNITY, SET_WRAP, SET_HOLD, SET_RANDOM};

  tick_row_t directed_rows [20] = '{
    '{8'(SET_KEEP),     16'sd0,      1'b0, 16'sd0,      1'b0, 1'b1, 16'sd27853},
    // speed gain zero: output holds
    '{8'(SET_KEEP),     16'sh8000,   1'b1, 16'sh8000,   1'b1, 1'b1, 16'sd27853},
    '{8'(SET_KEEP),     16'sh7FFF,   1'b1, 16'sh7FFF,   1'b1, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sh5555,   1'b0, 16'shAAAA,   1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'shAAAA,   1'b1, 16'sh5555,   1'b1, 1'b0, 16'sd0},
    '{8'(SET_ALL_LOW),  16'sd0,      1'b0, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sh7FFF,   1'b1, 16'sh8000,   1'b1, 1'b0, 16'sd0},
    '{8'(SET_ALL_HIGH), 16'sh7FFF,   1'b1, 16'sh7FFF,   1'b1, 1'b0, 16'sd0},
    // half rate gain pulls the logistic rate under its floor
    '{8'(SET_KEEP),     16'sh8000,   1'b1, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'shFFFF,   1'b0, 16'shFFFF,   1'b1, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sd0,      1'b0, 16'sd0,      1'b0, 1'b0, 16'sd0},
    // rate 2.0 in n-fold mode doubles the seed until it hits zero and reloads
    '{8'(SET_DOUBLING), 16'sd0,      1'b1, 16'sh7FFF,   1'b1, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sh1234,   1'b0, 16'sh4321,   1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'shFFFF,   1'b0, 16'sh0001,   1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sd0,      1'b1, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sh7FFF,   1'b0, 16'sh8000,   1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sd0,      1'b0, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sh0F0F,   1'b0, 16'shF0F0,   1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sd0,      1'b0, 16'sd0,      1'b0, 1'b0, 16'sd0},
    '{8'(SET_KEEP),     16'sh00FF,   1'b0, 16'shFF00,   1'b0, 1'b0, 16'sd0}
  };

  // predictor state
  logic [15:0]        m_base_rate;
  logic [15:0]        m_update_rate;
  logic [16:0]        m_init_seed;
  logic               m_mode;
  logic [16:0]        m_seed;
  logic [16:0]        m_rate_gain;
  logic [16:0]        m_speed_gain;
  int unsigned        m_tick;
  logic signed [15:0] m_held;

  logic signed [15:0] pending_samples [$];
  int                 mismatch_count = 0;
  int                 idle_mode = 0;
  int                 holds_asked = 0;
  int                 holds_given = 0;
  int                 hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int send_idle_pct();
    case (idle_mode)
      0:       return 9;
      1:       return 84;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (idle_mode)
      0:       return 84;
      1:       return 9;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_mod_sample();
    logic signed [15:0] v;
    case ($urandom_range(7))
      0:       v = 16'sh8000;
      1:       v = 16'sh7FFF;
      2:       v = 16'sd0;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic void iterate_map();
    logic [63:0] rate;
    logic [63:0] s;
    logic [63:0] r;
    rate = (64'(m_base_rate) * 64'(m_rate_gain)) >> 16;
    if (rate < RATE_FLOOR) rate = RATE_FLOOR;
    if (rate > RATE_CEIL) rate = RATE_CEIL;
    if (m_seed == 17'd0) m_seed = m_init_seed;
    if (64'(m_seed) > UNITY_Q16) m_seed = 17'(UNITY_Q16);
    s = 64'(m_seed);
    if (m_mode == cmo_pkg::MODE_LOGISTIC) begin
      r = (rate < LOGI_FLOOR) ? LOGI_FLOOR : rate;
      s = (r * s * (UNITY_Q16 - s)) >> 30;
    end else begin
      s = ((s * rate) & 64'h3FFF_FFFF) >> 14;
    end
    m_seed = s[16:0];
    // seed - 0.5 as a sample; only 1.0 and above saturate
    if (m_seed > 17'd65535) m_held = 16'sh7FFF;
    else m_held = $signed(m_seed[15:0] ^ 16'h8000);
  endfunction

  function automatic logic signed [15:0] oscillator_tick(input logic signed [15:0] rs,
                                                        input logic rv,
                                                        input logic signed [15:0] ss,
                                                        input logic sv);
    logic [63:0] den;
    logic [63:0] period;
    logic signed [15:0] sample;
    if (rv) m_rate_gain = {1'b0, rs ^ 16'h8000} + 17'd32768;
    if (sv) m_speed_gain = {1'b0, ss ^ 16'h8000};
    den = PERIOD_DEN * 64'(m_update_rate) * 64'(m_speed_gain);
    if (den != 64'd0) begin
      period = PERIOD_NUMR / den;
      if (period == 64'd0) period = 64'd1;
      if (64'(m_tick) % period == 64'd0) iterate_map();
    end
    sample = m_held;
    m_tick = m_tick + 1;
    if (m_tick >= SAMPLE_RATE) m_tick = 0;
    return sample;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_tick(input logic signed [15:0] rs, input logic rv,
                           input logic signed [15:0] ss, input logic sv,
                           input logic known, input logic signed [15:0] known_out);
    logic signed [15:0] predicted;
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_rate_mod_sample  <= rs;
    in_rate_mod_valid   <= rv;
    in_speed_mod_sample <= ss;
    in_speed_mod_valid  <= sv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = oscillator_tick(rs, rv, ss, sv);
    pending_samples.push_back(known ? known_out : predicted);
  endtask

  // stop offering and wait until every pending sample is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input osc_setting_t s);
    cfg_we    <= 1'b1;
    cfg_addr  <= cmo_pkg::CFG_BASE_RATE;
    cfg_wdata <= {1'b0, s.base_rate};
    @(posedge clk);
    cfg_addr  <= cmo_pkg::CFG_UPDATE_RATE;
    cfg_wdata <= {1'b0, s.update_rate};
    @(posedge clk);
    cfg_addr  <= cmo_pkg::CFG_INITIAL_SEED;
    cfg_wdata <= s.seed;
    @(posedge clk);
    cfg_addr  <= cmo_pkg::CFG_MAP_MODE;
    cfg_wdata <= {16'd0, s.mode};
    @(posedge clk);
    cfg_we <= 1'b0;
    m_base_rate   = s.base_rate;
    m_update_rate = s.update_rate;
    m_init_seed   = s.seed;
    m_mode        = s.mode;
  endtask

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_given) begin
      holds_given <= holds_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct());
    end
  end

  always @(posedge clk) begin : result_check
    logic signed [15:0] want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch($sformatf("sample %0d with nothing pending", out_sample_out));
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_out !== want)
          flag_mismatch($sformatf("sample_out want %0d got %0d", want, out_sample_out));
      end
    end
  end

  // ends the run if no beat moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    tick_row_t row;
    int random_sent;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_addr            = cmo_pkg::CFG_BASE_RATE;
    cfg_wdata           = 17'd0;
    in_valid            = 1'b0;
    in_rate_mod_sample  = 16'sd0;
    in_rate_mod_valid   = 1'b0;
    in_speed_mod_sample = 16'sd0;
    in_speed_mod_valid  = 1'b0;
    m_base_rate   = 16'd60621;
    m_update_rate = 16'd11025;
    m_init_seed   = 17'd32768;
    m_mode        = cmo_pkg::MODE_LOGISTIC;
    m_seed        = 17'd32768;
    m_rate_gain   = 17'(UNITY_Q16);
    m_speed_gain  = 17'(UNITY_Q16);
    m_tick        = 0;
    m_held        = 16'sd0;
    random_sent   = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.setting >= 0) begin
        settle();
        apply_setting(setting_table[row.setting]);
      end
      send_tick(row.rate_smp, row.rate_vld, row.speed_smp, row.speed_vld,
                row.known, row.known_out);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (phase_plan[p] == SET_RANDOM) begin
        setting_table[SET_RANDOM].base_rate   = 16'($urandom);
        setting_table[SET_RANDOM].update_rate = 16'($urandom_range(44100));
        setting_table[SET_RANDOM].seed        = 17'($urandom_range(65536));
        setting_table[SET_RANDOM].mode        = 1'($urandom_range(1));
      end
      settle();
      apply_setting(setting_table[phase_plan[p]]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        idle_mode = (random_sent < 210) ? 0 : (random_sent < 420) ? 1 : 2;
        if (random_sent == PRESSURE_AT) holds_asked++;
        send_tick(pick_mod_sample(), 1'($urandom_range(1)),
                  pick_mod_sample(), 1'($urandom_range(1)), 1'b0, 16'sd0);
        random_sent++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
